// File: sv/lfi_pkg.sv
// ----------------------------------------------------------------------------
// lfi_pkg
// Shared types and constants of the line fit block with inlier list.
// ----------------------------------------------------------------------------
`default_nettype none

package lfi_pkg;

  // Fixed field widths.
  localparam int COORD_W = 24;
  localparam int THR_W   = 23;
  localparam int DIR_W   = 18;
  localparam int DIR_FRAC = 16;

  // Shared divider: numerator and denominator widths.
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 34;

  // Shared square root unit: radicand and root widths.
  localparam int SQ_IW = 64;
  localparam int SQ_OW = 32;

  // Covariance terms are scaled until every magnitude is below 2^29.
  localparam int SCALE_LIM_BIT = 29;

  // Squared norm limit for a direction of (almost) zero length, before scaling.
  localparam logic [26:0] TINY_NORM = 27'd73786976;

  // One in Q1.16.
  localparam logic [16:0] DIR_ONE = 17'd65536;

  // Reset value of the distance threshold.
  localparam logic [THR_W-1:0] THR_RESET = 23'd3277;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_FEW_POINTS  = 2'd1,
    STATUS_NEG_DISC    = 2'd2,
    STATUS_FEW_INLIERS = 2'd3
  } status_t;

  typedef enum logic {
    KIND_LINE   = 1'b0,
    KIND_INLIER = 1'b1
  } kind_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_MEAN_X,
    ST_MEAN_Y,
    ST_COV_RD,
    ST_COV_MUL,
    ST_COV_ACC,
    ST_MAG,
    ST_SCALE,
    ST_SQUARE,
    ST_DISC,
    ST_ROOT,
    ST_DIR_SQ,
    ST_NORM,
    ST_TINY,
    ST_NORM_ROOT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_INL_RD,
    ST_INL_MUL,
    ST_INL_CMP,
    ST_EMIT_LINE,
    ST_SCAN,
    ST_EMIT_INL
  } fit_state_t;

endpackage

`default_nettype wire

// File: sv/lfi_point_mem.sv
// ----------------------------------------------------------------------------
// lfi_point_mem
// Point store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfi_point_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [AW-1:0]                          waddr,
  input  logic signed [lfi_pkg::COORD_W-1:0]     wr_x,
  input  logic signed [lfi_pkg::COORD_W-1:0]     wr_y,
  input  logic [AW-1:0]                          raddr,
  output logic signed [lfi_pkg::COORD_W-1:0]     rd_x,
  output logic signed [lfi_pkg::COORD_W-1:0]     rd_y
);

  logic signed [lfi_pkg::COORD_W-1:0] mem_x [DEPTH];
  logic signed [lfi_pkg::COORD_W-1:0] mem_y [DEPTH];

  // Write on enable, read every cycle into registered outputs.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wr_x;
      mem_y[waddr] <= wr_y;
    end
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
  end

endmodule

`default_nettype wire

// File: sv/lfi_divider.sv
// ----------------------------------------------------------------------------
// lfi_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfi_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lfi_pkg::DIV_NW-1:0]    num,
  input  logic [lfi_pkg::DIV_DW-1:0]    den,
  output logic                          done,
  output logic [lfi_pkg::DIV_NW-1:0]    quot
);

  localparam int NW   = lfi_pkg::DIV_NW;
  localparam int DW   = lfi_pkg::DIV_DW;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] steps;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   divisor;
  logic [DW:0]     trial;
  logic            fits;

  // Bring down the next numerator bit and test against the divisor.
  always_comb begin
    trial = {rem, quot[NW-1]};
    fits  = trial >= {1'b0, divisor};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The numerator shifts out of quot while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quot    <= num;
      divisor <= den;
    end else if (busy) begin
      rem  <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quot <= {quot[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: sv/lfi_sqrt.sv
// ----------------------------------------------------------------------------
// lfi_sqrt
// Integer square root (floor), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfi_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lfi_pkg::SQ_IW-1:0]    src,
  output logic                         done,
  output logic [lfi_pkg::SQ_OW-1:0]    root
);

  localparam int IW   = lfi_pkg::SQ_IW;
  localparam int OW   = lfi_pkg::SQ_OW;
  localparam int REMW = OW + 1;
  localparam int CNTW = $clog2(OW + 1);

  logic            busy;
  logic [CNTW-1:0] steps;
  logic [IW-1:0]   radicand;
  logic [REMW-1:0] rem;
  logic [OW+2:0]   shifted;
  logic [OW+2:0]   trial;
  logic            fits;

  // Bring down the next two radicand bits and test 4*root+1.
  always_comb begin
    shifted = {rem, radicand[IW-1:IW-2]};
    trial   = {1'b0, root, 2'b01};
    fits    = shifted >= trial;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(OW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Digit recurrence on remainder and partial root.
  always_ff @(posedge clk) begin
    if (start) begin
      radicand <= src;
      rem      <= '0;
      root     <= '0;
    end else if (busy) begin
      radicand <= {radicand[IW-3:0], 2'b00};
      rem      <= fits ? REMW'(shifted - trial) : REMW'(shifted);
      root     <= {root[OW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: sv/line_fit_with_inliers.sv
// ----------------------------------------------------------------------------
// line_fit_with_inliers
// Total least squares line fit over a stored point set, followed by the
// list of points within a perpendicular distance threshold.
// ----------------------------------------------------------------------------
//  Channel  Handshake                Word contents
//  input    in_valid / in_ready      point_x, point_y, final_point
//  output   out_valid / out_ready    line result, then one word per inlier
//  config   cfg_wr_en                cfg_wr_data = distance_threshold
//
// Points load one per cycle into the point store while the sums accumulate.
// After the final point the fit divides twice for the mean, then makes a
// pass over the stored points for the covariance (one store read each),
// applies at most 25 covariance scaling shifts, takes two square roots,
// divides twice for the direction and makes a second pass over the points
// for the inlier test (again one store read each). A direction of tiny
// norm skips the second root and both divisions. No point is accepted
// while a fit runs or its words are being delivered; output stalls simply
// hold the current word. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module line_fit_with_inliers #(
  parameter int MAX_POINTS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lfi_pkg::COORD_W-1:0]    point_x,
  input  logic signed [lfi_pkg::COORD_W-1:0]    point_y,
  input  logic                                  final_point,
  input  logic                                  cfg_wr_en,
  input  logic [lfi_pkg::THR_W-1:0]             cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  kind,
  output logic [1:0]                            status,
  output logic                                  overflow,
  output logic [5:0]                            point_count,
  output logic [5:0]                            inlier_total,
  output logic signed [lfi_pkg::COORD_W-1:0]    mean_x,
  output logic signed [lfi_pkg::COORD_W-1:0]    mean_y,
  output logic signed [lfi_pkg::DIR_W-1:0]      dir_x,
  output logic signed [lfi_pkg::DIR_W-1:0]      dir_y,
  output logic [4:0]                            inlier_index,
  output logic                                  last_result
);

  localparam int CRW  = lfi_pkg::COORD_W;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SUMW = CRW + CW;
  localparam int EW   = CRW + 1;
  localparam int PW   = 2 * EW;
  localparam int ACCW = PW + CW;
  localparam int SHW  = $clog2(ACCW + 1);
  localparam int LIM  = lfi_pkg::SCALE_LIM_BIT;
  localparam int ABW  = LIM + 1;
  localparam int DX2W = ABW + 1;
  localparam int DY2W = ABW + 2;
  localparam int DNW  = lfi_pkg::DIV_NW;
  localparam int DDW  = lfi_pkg::DIV_DW;
  localparam int SIW  = lfi_pkg::SQ_IW;
  localparam int SOW  = lfi_pkg::SQ_OW;
  localparam int DRW  = lfi_pkg::DIR_W;
  localparam int DPW  = DRW + EW;
  localparam int SDW  = DPW + 1;
  localparam int FRAC = lfi_pkg::DIR_FRAC;

  lfi_pkg::fit_state_t state, state_next;

  // Loading state and configuration.
  logic [CW-1:0]                cnt;
  logic signed [SUMW-1:0]       sum_x;
  logic signed [SUMW-1:0]       sum_y;
  logic                         dropped;
  logic [lfi_pkg::THR_W-1:0]    thr;

  // Sequencing.
  logic [CW-1:0]                idx;
  logic [CW-1:0]                nin;
  logic [CW-1:0]                left;
  logic [MAX_POINTS-1:0]        mask;
  logic                         unit_wait;
  logic                         run_done;
  logic                         in_take;
  logic                         mem_we;
  logic [AW-1:0]                mem_raddr;
  logic signed [CRW-1:0]        rd_x;
  logic signed [CRW-1:0]        rd_y;

  // Fit datapath.
  logic signed [CRW-1:0]        mx;
  logic signed [CRW-1:0]        my;
  logic signed [EW-1:0]         ex;
  logic signed [EW-1:0]         ey;
  logic signed [PW-1:0]         prod_xx;
  logic signed [PW-1:0]         prod_yy;
  logic signed [PW-1:0]         prod_xy;
  logic [ACCW-1:0]              cxx;
  logic [ACCW-1:0]              cyy;
  logic signed [ACCW-1:0]       cxy;
  logic [ACCW-1:0]              cxym;
  logic                         cxy_neg;
  logic [SHW-1:0]               shift;
  logic                         too_big;
  logic signed [ABW-1:0]        ab_a;
  logic signed [ABW-1:0]        ab_b;
  logic signed [2*ABW-1:0]      a2;
  logic signed [2*ABW-1:0]      b2;
  logic [SIW-1:0]               disc;
  logic [SOW-1:0]               r;
  logic signed [DX2W-1:0]       dx2;
  logic signed [DY2W-1:0]       dy2;
  logic signed [2*DX2W-1:0]     dx2sq;
  logic signed [2*DY2W-1:0]     dy2sq;
  logic [SIW-1:0]               n2;
  logic                         tiny;
  logic [SOW-1:0]               h;
  logic signed [DRW-1:0]        dxo;
  logic signed [DRW-1:0]        dyo;
  logic signed [DPW-1:0]        p1;
  logic signed [DPW-1:0]        p2;
  logic signed [SDW-1:0]        perp_d;
  logic [SDW-1:0]               dist_mag;
  logic                         is_inlier;

  // Shared unit operands.
  logic                         div_start;
  logic                         div_done;
  logic [DNW-1:0]               div_num;
  logic [DDW-1:0]               div_den;
  logic [DNW-1:0]               div_quot;
  logic                         sqrt_start;
  logic                         sqrt_done;
  logic [SIW-1:0]               sqrt_src;
  logic [SOW-1:0]               sqrt_root;
  logic signed [SUMW-1:0]       sum_sel;
  logic                         sum_neg;
  logic [SUMW-1:0]              sum_mag;
  logic signed [CRW-1:0]        mean_res;
  logic signed [DY2W-1:0]       d_sel;
  logic                         d_neg;
  logic [DY2W-1:0]              d_mag;
  logic [FRAC:0]                sat_mag;
  logic signed [DRW-1:0]        dir_res;

  assign in_ready = (state == lfi_pkg::ST_LOAD);
  assign in_take  = in_valid && in_ready;
  assign mem_we   = in_take && (cnt < CW'(MAX_POINTS));

  lfi_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt[AW-1:0]),
    .wr_x  (point_x),
    .wr_y  (point_y),
    .raddr (mem_raddr),
    .rd_x  (rd_x),
    .rd_y  (rd_y)
  );

  lfi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  lfi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .src   (sqrt_src),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Offsets of the point just read from the mean.
  assign ex = EW'(rd_x) - EW'(mx);
  assign ey = EW'(rd_y) - EW'(my);

  // Scaled covariance terms and the doubled direction.
  assign too_big = (|cxx[ACCW-1:LIM]) || (|cyy[ACCW-1:LIM]) || (|cxym[ACCW-1:LIM]);
  assign ab_a    = signed'({1'b0, cxx[LIM-1:0]}) - signed'({1'b0, cyy[LIM-1:0]});
  assign ab_b    = cxy_neg ? -signed'({1'b0, cxym[LIM-1:0]}) : signed'({1'b0, cxym[LIM-1:0]});
  assign dx2     = {ab_b, 1'b0};
  assign dy2     = DY2W'(signed'({1'b0, r})) - DY2W'(ab_a);
  assign tiny    = n2 <= ({{(SIW-27){1'b0}}, lfi_pkg::TINY_NORM} >> {shift, 1'b0});

  // Mean division: round half away from zero via (2|s| + n) / 2n.
  assign sum_sel  = (state == lfi_pkg::ST_MEAN_X) ? sum_x : sum_y;
  assign sum_neg  = sum_sel[SUMW-1];
  assign sum_mag  = sum_neg ? SUMW'(-sum_sel) : SUMW'(sum_sel);
  assign mean_res = CRW'(sum_neg ? -div_quot : div_quot);

  // Direction division: (2|c|*65536 + h) / 2h, then saturate.
  assign d_sel   = (state == lfi_pkg::ST_DIV_X) ? DY2W'(dx2) : dy2;
  assign d_neg   = d_sel[DY2W-1];
  assign d_mag   = d_neg ? DY2W'(-d_sel) : DY2W'(d_sel);
  assign sat_mag = (div_quot > DNW'(lfi_pkg::DIR_ONE)) ? lfi_pkg::DIR_ONE : div_quot[FRAC:0];
  assign dir_res = d_neg ? -signed'({1'b0, sat_mag}) : signed'({1'b0, sat_mag});

  // Perpendicular distance test.
  assign perp_d    = SDW'(p1) - SDW'(p2);
  assign dist_mag  = perp_d[SDW-1] ? SDW'(-perp_d) : SDW'(perp_d);
  assign is_inlier = dist_mag <= SDW'({thr, {FRAC{1'b0}}});

  // Unit operand selection.
  always_comb begin
    if (state == lfi_pkg::ST_DIV_X || state == lfi_pkg::ST_DIV_Y) begin
      div_num = DNW'({d_mag, {(FRAC + 1){1'b0}}}) + DNW'(h);
      div_den = DDW'({h, 1'b0});
    end else begin
      div_num = DNW'({sum_mag, 1'b0}) + DNW'(cnt);
      div_den = DDW'({cnt, 1'b0});
    end
    sqrt_src = (state == lfi_pkg::ST_ROOT) ? disc : n2;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfi_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    run_done   = 1'b0;
    mem_raddr  = idx[AW-1:0];
    unique case (state)
      lfi_pkg::ST_LOAD: begin
        if (in_valid && final_point) state_next = lfi_pkg::ST_MEAN_X;
      end
      lfi_pkg::ST_MEAN_X: begin
        if (cnt < CW'(2)) begin
          state_next = lfi_pkg::ST_EMIT_LINE;
        end else begin
          div_start = !unit_wait;
          if (div_done) state_next = lfi_pkg::ST_MEAN_Y;
        end
      end
      lfi_pkg::ST_MEAN_Y: begin
        div_start = !unit_wait;
        if (div_done) state_next = lfi_pkg::ST_COV_RD;
      end
      lfi_pkg::ST_COV_RD:  state_next = lfi_pkg::ST_COV_MUL;
      lfi_pkg::ST_COV_MUL: state_next = lfi_pkg::ST_COV_ACC;
      lfi_pkg::ST_COV_ACC: begin
        state_next = (CW'(idx + 1'b1) == cnt) ? lfi_pkg::ST_MAG : lfi_pkg::ST_COV_RD;
      end
      lfi_pkg::ST_MAG: state_next = lfi_pkg::ST_SCALE;
      lfi_pkg::ST_SCALE: begin
        if (!too_big) state_next = lfi_pkg::ST_SQUARE;
      end
      lfi_pkg::ST_SQUARE: state_next = lfi_pkg::ST_DISC;
      lfi_pkg::ST_DISC:   state_next = lfi_pkg::ST_ROOT;
      lfi_pkg::ST_ROOT: begin
        sqrt_start = !unit_wait;
        if (sqrt_done) state_next = lfi_pkg::ST_DIR_SQ;
      end
      lfi_pkg::ST_DIR_SQ: state_next = lfi_pkg::ST_NORM;
      lfi_pkg::ST_NORM:   state_next = lfi_pkg::ST_TINY;
      lfi_pkg::ST_TINY: begin
        state_next = tiny ? lfi_pkg::ST_INL_RD : lfi_pkg::ST_NORM_ROOT;
      end
      lfi_pkg::ST_NORM_ROOT: begin
        sqrt_start = !unit_wait;
        if (sqrt_done) state_next = lfi_pkg::ST_DIV_X;
      end
      lfi_pkg::ST_DIV_X: begin
        div_start = !unit_wait;
        if (div_done) state_next = lfi_pkg::ST_DIV_Y;
      end
      lfi_pkg::ST_DIV_Y: begin
        div_start = !unit_wait;
        if (div_done) state_next = lfi_pkg::ST_INL_RD;
      end
      lfi_pkg::ST_INL_RD:  state_next = lfi_pkg::ST_INL_MUL;
      lfi_pkg::ST_INL_MUL: state_next = lfi_pkg::ST_INL_CMP;
      lfi_pkg::ST_INL_CMP: begin
        state_next = (CW'(idx + 1'b1) == cnt) ? lfi_pkg::ST_EMIT_LINE : lfi_pkg::ST_INL_RD;
      end
      lfi_pkg::ST_EMIT_LINE: begin
        if (out_ready) begin
          if (nin == '0) begin
            run_done   = 1'b1;
            state_next = lfi_pkg::ST_LOAD;
          end else begin
            state_next = lfi_pkg::ST_SCAN;
          end
        end
      end
      lfi_pkg::ST_SCAN: begin
        if (mask[0]) state_next = lfi_pkg::ST_EMIT_INL;
      end
      lfi_pkg::ST_EMIT_INL: begin
        if (out_ready) begin
          if (left == CW'(1)) begin
            run_done   = 1'b1;
            state_next = lfi_pkg::ST_LOAD;
          end else begin
            state_next = lfi_pkg::ST_SCAN;
          end
        end
      end
      default: state_next = lfi_pkg::ST_LOAD;
    endcase
  end

  // Control registers: loading, counters, inlier mask, unit handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      dropped   <= 1'b0;
      thr       <= lfi_pkg::THR_RESET;
      idx       <= '0;
      nin       <= '0;
      left      <= '0;
      mask      <= '0;
      unit_wait <= 1'b0;
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;

      if (div_start || sqrt_start) begin
        unit_wait <= 1'b1;
      end else if (div_done || sqrt_done) begin
        unit_wait <= 1'b0;
      end

      unique case (state)
        lfi_pkg::ST_LOAD: begin
          mask <= '0;
          nin  <= '0;
          idx  <= '0;
          if (in_take) begin
            if (mem_we) begin
              cnt   <= cnt + 1'b1;
              sum_x <= sum_x + SUMW'(point_x);
              sum_y <= sum_y + SUMW'(point_y);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        lfi_pkg::ST_COV_ACC: idx <= idx + 1'b1;
        lfi_pkg::ST_MAG:     idx <= '0;
        lfi_pkg::ST_INL_CMP: begin
          if (is_inlier) begin
            mask[idx[AW-1:0]] <= 1'b1;
            nin               <= nin + 1'b1;
          end
          idx <= idx + 1'b1;
        end
        lfi_pkg::ST_EMIT_LINE: begin
          if (out_ready) begin
            idx  <= '0;
            left <= nin;
          end
        end
        lfi_pkg::ST_SCAN: begin
          if (!mask[0]) begin
            mask <= mask >> 1;
            idx  <= idx + 1'b1;
          end
        end
        lfi_pkg::ST_EMIT_INL: begin
          if (out_ready) begin
            mask <= mask >> 1;
            idx  <= idx + 1'b1;
            left <= left - 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Clear the loading state once the last word of the run is taken.
      if (run_done) begin
        cnt     <= '0;
        sum_x   <= '0;
        sum_y   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // Fit datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      lfi_pkg::ST_MEAN_X: begin
        if (cnt < CW'(2)) begin
          mx  <= '0;
          my  <= '0;
          dxo <= '0;
          dyo <= '0;
        end else if (div_done) begin
          mx <= mean_res;
        end
      end
      lfi_pkg::ST_MEAN_Y: begin
        if (div_done) my <= mean_res;
        cxx <= '0;
        cyy <= '0;
        cxy <= '0;
      end
      lfi_pkg::ST_COV_MUL: begin
        prod_xx <= ex * ex;
        prod_yy <= ey * ey;
        prod_xy <= ex * ey;
      end
      lfi_pkg::ST_COV_ACC: begin
        cxx <= cxx + ACCW'(prod_xx);
        cyy <= cyy + ACCW'(prod_yy);
        cxy <= cxy + ACCW'(prod_xy);
      end
      lfi_pkg::ST_MAG: begin
        cxy_neg <= cxy[ACCW-1];
        cxym    <= cxy[ACCW-1] ? ACCW'(-cxy) : ACCW'(cxy);
        shift   <= '0;
      end
      lfi_pkg::ST_SCALE: begin
        if (too_big) begin
          cxx   <= cxx >> 1;
          cyy   <= cyy >> 1;
          cxym  <= cxym >> 1;
          shift <= shift + 1'b1;
        end
      end
      lfi_pkg::ST_SQUARE: begin
        a2 <= ab_a * ab_a;
        b2 <= ab_b * ab_b;
      end
      lfi_pkg::ST_DISC: disc <= SIW'(a2) + (SIW'(b2) << 2);
      lfi_pkg::ST_ROOT: begin
        if (sqrt_done) r <= sqrt_root;
      end
      lfi_pkg::ST_DIR_SQ: begin
        dx2sq <= dx2 * dx2;
        dy2sq <= dy2 * dy2;
      end
      lfi_pkg::ST_NORM: n2 <= SIW'(dx2sq) + SIW'(dy2sq);
      lfi_pkg::ST_TINY: begin
        if (tiny) begin
          dxo <= signed'({1'b0, lfi_pkg::DIR_ONE});
          dyo <= '0;
        end
      end
      lfi_pkg::ST_NORM_ROOT: begin
        if (sqrt_done) h <= sqrt_root;
      end
      lfi_pkg::ST_DIV_X: begin
        if (div_done) dxo <= dir_res;
      end
      lfi_pkg::ST_DIV_Y: begin
        if (div_done) dyo <= dir_res;
      end
      lfi_pkg::ST_INL_MUL: begin
        p1 <= dxo * ey;
        p2 <= dyo * ex;
      end
      default: begin
      end
    endcase
  end

  // Output word: line result first, then one word per inlier.
  assign out_valid    = (state == lfi_pkg::ST_EMIT_LINE) || (state == lfi_pkg::ST_EMIT_INL);
  assign kind         = (state == lfi_pkg::ST_EMIT_INL) ? lfi_pkg::KIND_INLIER
                                                        : lfi_pkg::KIND_LINE;
  assign status       = (cnt < CW'(2)) ? lfi_pkg::STATUS_FEW_POINTS :
                        (nin < CW'(3)) ? lfi_pkg::STATUS_FEW_INLIERS : lfi_pkg::STATUS_OK;
  assign overflow     = dropped;
  assign point_count  = 6'(cnt);
  assign inlier_total = 6'(nin);
  assign mean_x       = mx;
  assign mean_y       = my;
  assign dir_x        = dxo;
  assign dir_y        = dyo;
  assign inlier_index = (state == lfi_pkg::ST_EMIT_INL) ? 5'(idx) : 5'd0;
  assign last_result  = (state == lfi_pkg::ST_EMIT_INL) ? (left == CW'(1)) : (nin == '0);

endmodule

`default_nettype wire

// File: sv/lfi_checker.sv
// ----------------------------------------------------------------------------
// lfi_checker
// Port-level checks of the line fit block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfi_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                kind,
  input wire logic signed [17:0]  dir_x,
  input wire logic signed [17:0]  dir_y,
  input wire logic [4:0]          inlier_index,
  input wire logic                last_result
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(inlier_index)
      && $stable(last_result))
    else $error("output word changed while stalled");

  // No point is taken while results are delivered.
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result word is shown");

  // The run ends with its last word.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_result |=> !out_valid)
    else $error("word shown after the last word of a run");

  // The line word carries index zero and a saturated direction.
  a_line_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> inlier_index == 5'd0 && dir_x <= 18'sd65536
      && dir_x >= -18'sd65536 && dir_y <= 18'sd65536 && dir_y >= -18'sd65536)
    else $error("bad line word");

endmodule

bind line_fit_with_inliers lfi_checker u_lfi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .dir_x        (dir_x),
  .dir_y        (dir_y),
  .inlier_index (inlier_index),
  .last_result  (last_result)
);

`default_nettype wire

// File: test/line_fit_with_inliers_tb.sv
// ----------------------------------------------------------------------------
// line_fit_with_inliers_tb
// Self-checking bench for the line fit block. Point sets are driven through
// the input channel with bursty timing, and every output word is checked
// against a bit-exact fit predictor. The output side stalls on its own
// pattern. The distance threshold is changed between sets while the block
// is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module line_fit_with_inliers_tb;

  localparam int NPTS = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_POINTS = 470;

  // One output word, as seen on the result ports.
  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic       overflow;
    logic [5:0] point_count;
    logic [5:0] inlier_total;
    logic [23:0] mean_x;
    logic [23:0] mean_y;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [4:0] inlier_index;
    logic       last_result;
  } fit_word_t;

  // Fit predictor and store of expected output words.
  class fit_scoreboard;
    longint       pts_x[NPTS];
    longint       pts_y[NPTS];
    int           n_stored;
    longint       acc_x, acc_y;
    bit           dropped;
    longint       thresh;
    fit_word_t    expected_words[$];
    int           errors;

    function new();
      n_stored = 0;
      acc_x = 0;
      acc_y = 0;
      dropped = 0;
      thresh = lfi_pkg::THR_RESET;
      errors = 0;
    endfunction

    static function longint div_near(longint num, longint den);
      longint unsigned m, q;
      m = num < 0 ? -num : num;
      q = (2 * m + den) / (2 * den);
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    static function longint clip_dir(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    // Note one accepted point; a final point produces the expected words.
    function void note_point(logic signed [23:0] px, logic signed [23:0] py, bit fin);
      longint mx, my, ex, ey, cxy, a, b, dx2, dy2, dxo, dyo, d, h;
      longint unsigned cxx, cyy, disc, r, n2, tiny, lim, mcxy;
      int s, nin;
      int inl[$];
      fit_word_t w;
      mx = 0; my = 0; dxo = 0; dyo = 0; nin = 0;
      if (n_stored < NPTS) begin
        pts_x[n_stored] = px;
        pts_y[n_stored] = py;
        n_stored++;
        acc_x += px;
        acc_y += py;
      end else begin
        dropped = 1;
      end
      if (!fin) return;
      w = '0;
      if (n_stored < 2) begin
        w.status = lfi_pkg::STATUS_FEW_POINTS;
      end else begin
        mx = div_near(acc_x, n_stored);
        my = div_near(acc_y, n_stored);
        cxx = 0; cyy = 0; cxy = 0;
        for (int i = 0; i < n_stored; i++) begin
          ex = pts_x[i] - mx;
          ey = pts_y[i] - my;
          cxx += ex * ex;
          cyy += ey * ey;
          cxy += ex * ey;
        end
        // Common scale so every covariance term fits below 2^29.
        lim = 64'd1 << lfi_pkg::SCALE_LIM_BIT;
        mcxy = cxy < 0 ? -cxy : cxy;
        s = 0;
        while ((cxx >> s) >= lim || (cyy >> s) >= lim || (mcxy >> s) >= lim) s++;
        a = longint'(cxx >> s) - longint'(cyy >> s);
        b = cxy < 0 ? -longint'(mcxy >> s) : longint'(mcxy >> s);
        disc = a * a + 4 * b * b;
        r = int_sqrt(disc);
        dx2 = 2 * b;
        dy2 = longint'(r) - a;
        n2 = dx2 * dx2 + dy2 * dy2;
        tiny = s < 32 ? (64'(lfi_pkg::TINY_NORM) >> (2 * s)) : 0;
        if (n2 <= tiny) begin
          dxo = lfi_pkg::DIR_ONE;
          dyo = 0;
        end else begin
          h = longint'(int_sqrt(n2));
          dxo = clip_dir(div_near(dx2 * 65536, h));
          dyo = clip_dir(div_near(dy2 * 65536, h));
        end
        // Perpendicular distance test for every stored point.
        for (int i = 0; i < n_stored; i++) begin
          ex = pts_x[i] - mx;
          ey = pts_y[i] - my;
          d = dxo * ey - dyo * ex;
          if (d < 0) d = -d;
          if (d <= (thresh << 16)) inl = {inl, i};
        end
        nin = inl.size();
        w.status = nin < 3 ? lfi_pkg::STATUS_FEW_INLIERS : lfi_pkg::STATUS_OK;
      end
      w.kind = lfi_pkg::KIND_LINE;
      w.overflow = dropped;
      w.point_count = 6'(n_stored);
      w.inlier_total = 6'(nin);
      w.mean_x = mx[23:0];
      w.mean_y = my[23:0];
      w.dir_x = dxo[17:0];
      w.dir_y = dyo[17:0];
      w.inlier_index = '0;
      w.last_result = (nin == 0);
      expected_words = {expected_words, w};
      for (int i = 0; i < nin; i++) begin
        w.kind = lfi_pkg::KIND_INLIER;
        w.inlier_index = 5'(inl[i]);
        w.last_result = (i + 1 == nin);
        expected_words = {expected_words, w};
      end
      n_stored = 0;
      acc_x = 0;
      acc_y = 0;
      dropped = 0;
    endfunction

    function void field_cmp(string name, longint e, longint g);
      if (e != g) begin
        $error("%s: expected %0d, got %0d", name, e, g);
        errors++;
      end
    endfunction

    // Compare one accepted output word with the oldest expectation.
    function void check_word(fit_word_t g);
      fit_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected output word, kind %0d index %0d", g.kind, g.inlier_index);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      field_cmp("kind", e.kind, g.kind);
      field_cmp("status", e.status, g.status);
      field_cmp("overflow", e.overflow, g.overflow);
      field_cmp("point_count", e.point_count, g.point_count);
      field_cmp("inlier_total", e.inlier_total, g.inlier_total);
      field_cmp("mean_x", e.mean_x, g.mean_x);
      field_cmp("mean_y", e.mean_y, g.mean_y);
      field_cmp("dir_x", e.dir_x, g.dir_x);
      field_cmp("dir_y", e.dir_y, g.dir_y);
      field_cmp("inlier_index", e.inlier_index, g.inlier_index);
      field_cmp("last_result", e.last_result, g.last_result);
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready;
  logic signed [lfi_pkg::COORD_W-1:0] point_x, point_y;
  logic final_point;
  logic cfg_wr_en;
  logic [lfi_pkg::THR_W-1:0] cfg_wr_data;
  logic out_valid, out_ready;
  logic kind, overflow, last_result;
  logic [1:0] status;
  logic [5:0] point_count, inlier_total;
  logic signed [lfi_pkg::COORD_W-1:0] mean_x, mean_y;
  logic signed [lfi_pkg::DIR_W-1:0] dir_x, dir_y;
  logic [4:0] inlier_index;

  fit_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int points_sent = 0;

  line_fit_with_inliers #(.MAX_POINTS(NPTS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .final_point(final_point),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .overflow(overflow),
    .point_count(point_count), .inlier_total(inlier_total),
    .mean_x(mean_x), .mean_y(mean_y), .dir_x(dir_x), .dir_y(dir_y),
    .inlier_index(inlier_index), .last_result(last_result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Output stall pattern: modes of random length, from never stalling
  // to mostly stalled.
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 120);
      end
      mode_left--;
      case (mode)
        0: out_ready = 1;
        1: out_ready = $urandom_range(0, 1);
        default: out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Cycle limit and output word monitor.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_fit_with_inliers_tb: errors");
      $finish;
    end
    if (!rst && out_valid && out_ready)
      sb.check_word({kind, status, overflow, point_count, inlier_total,
                     mean_x, mean_y, dir_x, dir_y, inlier_index, last_result});
  end

  // Send one point word; the sender works in bursts with random gaps.
  task automatic send_point(int px, int py, bit fin);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1;
    point_x = 24'(px);
    point_y = 24'(py);
    final_point = fin;
    do @(posedge clk); while (!in_ready);
    sb.note_point(point_x, point_y, fin);
    points_sent++;
  endtask

  // Let every expected word drain, then give the block time to settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_threshold(int unsigned v);
    wait_idle();
    cfg_wr_en = 1;
    cfg_wr_data = 23'(v);
    @(negedge clk);
    cfg_wr_en = 0;
    sb.thresh = v & 32'h7FFFFF;
  endtask

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  // One random set: mostly noisy points along a line, sometimes pure noise.
  task automatic random_set();
    int n, sel, cx, cy, ux, uy, amp, t, px, py, rx, ry;
    bit noise_only;
    sel = $urandom_range(0, 19);
    if (sel == 0) n = 1;
    else if (sel < 13) n = $urandom_range(2, 12);
    else if (sel < 18) n = $urandom_range(13, 32);
    else n = $urandom_range(33, 40);
    noise_only = ($urandom_range(0, 4) == 0);
    cx = $urandom_range(0, 8388607) - 4194304;
    cy = $urandom_range(0, 8388607) - 4194304;
    ux = $urandom_range(0, 2000) - 1000;
    uy = $urandom_range(0, 2000) - 1000;
    case ($urandom_range(0, 2))
      0: amp = 0;
      1: amp = 16;
      default: amp = 4000;
    endcase
    for (int i = 0; i < n; i++) begin
      if (noise_only) begin
        sel = $urandom_range(0, 9);
        rx = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        ry = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        px = sel == 0 ? -8388608 : sel == 1 ? 8388607 : rx;
        py = sel == 0 ? 8388607 : sel == 1 ? -8388608 : ry;
      end else begin
        t = $urandom_range(0, 4000) - 2000;
        px = clamp24(longint'(cx) + t * ux + $urandom_range(0, 2 * amp) - amp);
        py = clamp24(longint'(cy) + t * uy + $urandom_range(0, 2 * amp) - amp);
      end
      send_point(px, py, i == n - 1);
    end
  endtask

  initial begin
    int phase;
    rst = 1;
    in_valid = 0;
    point_x = 0;
    point_y = 0;
    final_point = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed sets at the reset threshold, the last two at thresholds 0 and 8388607.
    send_point(1000, -1000, 1);                 // a single point
    send_point(-8388608, -8388608, 0);          // two points at the extremes
    send_point(8388607, 8388607, 1);
    repeat (2) send_point(12345, -777, 0);      // identical points: tiny norm
    send_point(12345, -777, 1);
    send_point(-8388608, 8388607, 0);           // opposite corners
    send_point(8388607, -8388608, 0);
    send_point(0, 0, 1);
    for (int i = 0; i < 4; i++) send_point(5000, i * 70000, i == 3);      // vertical
    for (int i = 0; i < 4; i++) send_point(i * 65536, i * 65536 + (i == 2 ? 9000 : 0), i == 3);
    set_threshold(0);
    for (int i = 0; i < 3; i++) send_point(i * 100, -i * 100, i == 2);   // exact line
    set_threshold(8388607);
    for (int i = 0; i < 3; i++) send_point(i * 3000000 - 4000000, (i % 2) * 8000000, i == 2);

    // Random sets over a series of threshold settings.
    phase = 0;
    while (points_sent < RANDOM_POINTS) begin
      if (phase % 6 == 0) begin
        case ((phase / 6) % 5)
          0: set_threshold(lfi_pkg::THR_RESET);
          1: set_threshold(0);
          2: set_threshold(8388607);
          3: set_threshold($urandom_range(0, 8388607));
          default: set_threshold($urandom_range(0, 200000));
        endcase
      end
      random_set();
      phase++;
    end

    wait_idle();
    repeat (600) @(negedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d expected output words never arrived", sb.expected_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("line_fit_with_inliers_tb: clean");
    end else begin
      $display("line_fit_with_inliers_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
